FILE: rtl/assert_macros.svh
// Assertion macros shared by the deque RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DQS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DQS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dqs_pkg.sv
// Types and constants for the record deque.
// No dependencies; imported by the channel interfaces, the cell and the top level.
package dqs_pkg;

   localparam int KEY_W    = 64;
   localparam int YEAR_W   = 14;
   localparam int TEXT_W   = 64;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_REAR  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_DUMP       = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [YEAR_W-1:0] year;
      logic [TEXT_W-1:0] brand;
      logic [TEXT_W-1:0] fuel;
   } record_type;

   // shift_up: take left neighbor (toward front); shift_down: take right neighbor
   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } cell_ctrl_type;

   typedef struct packed {
      status_type        status;
      record_type        rec;
      logic              last;
      logic [FILL_W-1:0] fill;
   } rsp_beat_type;

endpackage

FILE: rtl/dqs_channels.sv
// Valid/ready channel interfaces for the deque request and response beats.
// Depends on dqs_pkg for field widths.
interface dqs_req_if import dqs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [KEY_W-1:0]    model_key;
   logic [YEAR_W-1:0]   model_year;
   logic [TEXT_W-1:0]   brand_text;
   logic [TEXT_W-1:0]   fuel_text;
   logic                clear_all;

   modport source (output valid, opcode, model_key, model_year, brand_text, fuel_text,
                   clear_all, input ready);
   modport sink (input valid, opcode, model_key, model_year, brand_text, fuel_text,
                 clear_all, output ready);
endinterface

interface dqs_rsp_if import dqs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    out_key;
   logic [YEAR_W-1:0]   out_year;
   logic [TEXT_W-1:0]   out_brand;
   logic [TEXT_W-1:0]   out_fuel;
   logic                last_of_run;
   logic [FILL_W-1:0]   fill_level;

   modport source (output valid, status, out_key, out_year, out_brand, out_fuel,
                   last_of_run, fill_level, input ready);
   modport sink (input valid, status, out_key, out_year, out_brand, out_fuel,
                 last_of_run, fill_level, output ready);
endinterface

FILE: rtl/dqs_cell.sv
// One slot of the deque shift chain: holds a record, shifts toward either neighbor
// or loads the push record. Depends on dqs_pkg.
module dqs_cell import dqs_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          load_en,
   input  record_type    push_rec,
   input  record_type    left_rec,
   input  record_type    right_rec,
   output record_type    rec_out
);

   record_type rec_ff;
   record_type rec_in;

   always_comb begin
      priority if (ctrl.shift_up) begin
         rec_in = left_rec;
      end else if (ctrl.shift_down) begin
         rec_in = right_rec;
      end else if (load_en) begin
         rec_in = push_rec;
      end else begin
         rec_in = rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

FILE: rtl/double_ended_queue_with_search_top.sv
// Record deque built as a chain of shift cells, front record always in cell 0.
// Depends on dqs_pkg, dqs_channels.sv, dqs_cell and assert_macros.svh.
//
// Usage:
//   req_bus carries one operation per beat (push rear/front, pop front/rear,
//   search, dump, or clear_all). rsp_bus returns the result beats; every
//   request gives one beat except a dump of a non-empty deque, which gives
//   one beat per record front to rear, last_of_run marking the final one.
//   Pushes, pops, clear and errors: result registered in the cycle after the
//   request beat; a new request is taken every cycle while rsp_bus drains.
//   Search and dump rotate the whole cell chain once, one cell per cycle,
//   so they hold the request side for the whole rotation plus any response stall;
//   results appear as the matching records pass cell 0.
//   Reset clears the fill count and the sequencer; record cells are not reset.
//   A stalled rsp_bus holds its beat; the rotation pauses on a cycle that
//   must emit a beat until the output register frees.
`include "assert_macros.svh"

module double_ended_queue_with_search_top import dqs_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   dqs_req_if.sink   req_bus,
   dqs_rsp_if.source rsp_bus
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] step_ff, step_in;
   logic          dump_ff, dump_in;
   logic          found_ff, found_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type  rsp_beat_ff, rsp_beat_in;

   cell_ctrl_type ctrl;
   logic [DEPTH-1:0] load_vec;
   record_type    cell_rec [DEPTH];
   record_type    push_rec;
   record_type    tail_rec;
   record_type    emit_rec;
   status_type    emit_status;
   logic          emit_last;
   logic          emit;
   logic          emit_go;
   logic          out_free;
   logic          req_fire;
   logic          advance;
   logic          in_range;
   logic          last_step;
   logic          hit;
   logic          push_rear_go;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign push_rec = '{key:   req_bus.model_key,
                       year:  req_bus.model_year,
                       brand: req_bus.brand_text,
                       fuel:  req_bus.fuel_text};

   // cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      record_type left_rec;
      if (g == 0) begin : g_head
         assign left_rec = push_rec;
      end else begin : g_body
         assign left_rec = cell_rec[g-1];
      end
      dqs_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_en   (load_vec[g]),
         .push_rec  (push_rec),
         .left_rec  (left_rec),
         .right_rec (cell_rec[(g + 1) % DEPTH]),
         .rec_out   (cell_rec[g])
      );
   end

   always_comb begin
      tail_rec = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CW'(i) == count_ff - CW'(1)) begin
            tail_rec = cell_rec[i];
         end
      end
   end

   assign in_range  = CW'(step_ff) < count_ff;
   assign last_step = step_ff == SW'(DEPTH - 1);
   assign hit       = in_range && !found_ff && (cell_rec[0].key == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && !req_bus.clear_all && count_ff != '0 &&
                (opcode_type'(req_bus.opcode) == OP_SEARCH ||
                 opcode_type'(req_bus.opcode) == OP_DUMP)) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (advance && last_step) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control and result
   always_comb begin
      ctrl         = '0;
      push_rear_go = 1'b0;
      count_in     = count_ff;
      step_in      = step_ff;
      dump_in      = dump_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      emit         = 1'b0;
      emit_status  = ST_OK;
      emit_rec     = '0;
      emit_last    = 1'b1;
      advance      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               emit = 1'b1;
               if (req_bus.clear_all) begin
                  count_in = '0;
               end else begin
                  unique case (opcode_type'(req_bus.opcode))
                     OP_PUSH_REAR: begin
                        if (count_ff == CW'(DEPTH)) begin
                           emit_status = ST_FULL;
                        end else begin
                           push_rear_go = 1'b1;
                           count_in     = count_ff + CW'(1);
                        end
                     end
                     OP_PUSH_FRONT: begin
                        if (count_ff == CW'(DEPTH)) begin
                           emit_status = ST_FULL;
                        end else begin
                           ctrl.shift_up = 1'b1;
                           count_in      = count_ff + CW'(1);
                        end
                     end
                     OP_POP_FRONT: begin
                        if (count_ff == '0) begin
                           emit_status = ST_EMPTY;
                        end else begin
                           emit_rec        = cell_rec[0];
                           ctrl.shift_down = 1'b1;
                           count_in        = count_ff - CW'(1);
                        end
                     end
                     OP_POP_REAR: begin
                        if (count_ff == '0) begin
                           emit_status = ST_EMPTY;
                        end else begin
                           emit_rec = tail_rec;
                           count_in = count_ff - CW'(1);
                        end
                     end
                     OP_SEARCH, OP_DUMP: begin
                        if (count_ff == '0) begin
                           emit_status = ST_EMPTY;
                        end else begin
                           emit     = 1'b0;
                           step_in  = '0;
                           found_in = 1'b0;
                           dump_in  = opcode_type'(req_bus.opcode) == OP_DUMP;
                           key_in   = req_bus.model_key;
                        end
                     end
                     default: begin
                        emit_status = ST_OK;
                     end
                  endcase
               end
            end
         end
         S_WALK: begin
            if (dump_ff) begin
               emit      = in_range;
               emit_rec  = cell_rec[0];
               emit_last = (CW'(step_ff) + CW'(1)) == count_ff;
            end else begin
               emit        = hit || (last_step && !found_ff);
               emit_status = hit ? ST_OK : ST_NOT_FOUND;
               emit_rec    = hit ? cell_rec[0] : '0;
            end
            advance = !emit || out_free;
            if (advance) begin
               ctrl.shift_down = 1'b1;
               step_in         = step_ff + SW'(1);
               found_in        = found_ff || hit;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         load_vec[i] = push_rear_go && (CW'(i) == count_ff);
      end
   end

   assign emit_go = emit && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = '{status: emit_status,
                          rec:    emit_rec,
                          last:   emit_last,
                          fill:   FILL_W'(count_in)};
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         dump_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         dump_ff      <= dump_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_beat_ff.status;
   assign rsp_bus.out_key     = rsp_beat_ff.rec.key;
   assign rsp_bus.out_year    = rsp_beat_ff.rec.year;
   assign rsp_bus.out_brand   = rsp_beat_ff.rec.brand;
   assign rsp_bus.out_fuel    = rsp_beat_ff.rec.fuel;
   assign rsp_bus.last_of_run = rsp_beat_ff.last;
   assign rsp_bus.fill_level  = rsp_beat_ff.fill;

   `DQS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "fill count above depth")
   `DQS_ASSERT_IMPL(a_walk_blocks_req, clock, reset, state_ff == S_WALK, !req_bus.ready, "request taken during walk")
   `DQS_ASSERT_NEXT(a_walk_count_hold, clock, reset, state_ff == S_WALK, count_ff == $past(count_ff), "fill count moved during walk")

endmodule

FILE: bench/tb_double_ended_queue_with_search_top.sv
// Self-checking bench for the record deque: queued request beats, a shadow deque that
// predicts every response beat, random idling on both channels and one long response stall.
// Depends on dqs_pkg, dqs_channels.sv and double_ended_queue_with_search_top.
module tb_double_ended_queue_with_search_top;
   import dqs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int RANDOM_ITEMS = 210;
   localparam int QUIET_TAIL_ITEMS = 30;
   localparam int HOLD_AFTER_BEATS = 60;
   localparam int HOLD_CYCLES = 150;
   localparam longint TIMEOUT_NS = 10_000_000;
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND, MIX_QUERY} mix_type;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [KEY_W-1:0]    key;
      logic [YEAR_W-1:0]   year;
      logic [TEXT_W-1:0]   brand;
      logic [TEXT_W-1:0]   fuel;
      logic                clear;
   } deque_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dqs_req_if req_bus();
   dqs_rsp_if rsp_bus();

   double_ended_queue_with_search_top #(.DEPTH(DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow deque
   record_type  shelf [DEPTH];
   int unsigned shelf_head;
   int unsigned shelf_count;

   deque_req_type req_items [$];
   rsp_beat_type  expected_beats [$];
   deque_req_type offered_req;
   logic [KEY_W-1:0] key_pool [8];

   int  req_gap;
   int  rsp_stall;
   int  req_beats;
   int  rsp_beats;
   int  hold_left;
   bit  hold_taken;
   bit  quiet_tail;
   int  mismatch_count;

   function automatic void predict_results(input deque_req_type it);
      rsp_beat_type b;
      int unsigned  slot;
      int unsigned  i;
      bit           hit;
      b = '0;
      b.status = ST_OK;
      b.last = 1'b1;
      hit = 1'b0;
      if (it.clear) begin
         shelf_head = 0;
         shelf_count = 0;
      end else begin
         case (it.opcode)
            OP_PUSH_REAR, OP_PUSH_FRONT: begin
               if (shelf_count >= DEPTH) begin
                  b.status = ST_FULL;
               end else begin
                  if (it.opcode == OP_PUSH_REAR) begin
                     slot = (shelf_head + shelf_count) % DEPTH;
                  end else begin
                     shelf_head = (shelf_head + DEPTH - 1) % DEPTH;
                     slot = shelf_head;
                  end
                  shelf[slot] = '{key: it.key, year: it.year, brand: it.brand, fuel: it.fuel};
                  shelf_count++;
               end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
               if (shelf_count == 0) begin
                  b.status = ST_EMPTY;
               end else begin
                  if (it.opcode == OP_POP_FRONT) begin
                     slot = shelf_head;
                     shelf_head = (shelf_head + 1) % DEPTH;
                  end else begin
                     slot = (shelf_head + shelf_count - 1) % DEPTH;
                  end
                  shelf_count--;
                  b.rec = shelf[slot];
               end
            end
            OP_SEARCH: begin
               if (shelf_count == 0) begin
                  b.status = ST_EMPTY;
               end else begin
                  for (i = 0; i < shelf_count && !hit; i++) begin
                     slot = (shelf_head + i) % DEPTH;
                     if (shelf[slot].key == it.key) begin
                        hit = 1'b1;
                        b.rec = shelf[slot];
                     end
                  end
                  if (!hit) b.status = ST_NOT_FOUND;
               end
            end
            OP_DUMP: begin
               if (shelf_count == 0) begin
                  b.status = ST_EMPTY;
               end else begin
                  b.fill = FILL_W'(shelf_count);
                  for (i = 0; i < shelf_count; i++) begin
                     b.rec = shelf[(shelf_head + i) % DEPTH];
                     b.last = (i + 1 == shelf_count);
                     expected_beats.push_back(b);
                  end
                  return;
               end
            end
            default: ;
         endcase
      end
      b.fill = FILL_W'(shelf_count);
      expected_beats.push_back(b);
   endfunction

   function automatic deque_req_type make_req(input logic [OPCODE_W-1:0] op,
                                              input logic [KEY_W-1:0] key,
                                              input logic [YEAR_W-1:0] year,
                                              input logic [TEXT_W-1:0] brand,
                                              input logic [TEXT_W-1:0] fuel,
                                              input logic clear);
      deque_req_type r;
      r.opcode = op;
      r.key = key;
      r.year = year;
      r.brand = brand;
      r.fuel = fuel;
      r.clear = clear;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic deque_req_type random_req(input mix_type mix);
      int unsigned r;
      int unsigned push_cut;
      int unsigned pop_cut;
      int unsigned search_cut;
      int unsigned dump_cut;
      logic [OPCODE_W-1:0] op;
      logic [KEY_W-1:0] key;
      logic [YEAR_W-1:0] year;
      case (mix)
         MIX_FILL:  begin push_cut = 85; pop_cut = 89; search_cut = 94; dump_cut = 97; end
         MIX_DRAIN: begin push_cut = 15; pop_cut = 75; search_cut = 88; dump_cut = 95; end
         MIX_BLEND: begin push_cut = 40; pop_cut = 65; search_cut = 80; dump_cut = 93; end
         default:   begin push_cut = 20; pop_cut = 30; search_cut = 70; dump_cut = 95; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_cut)        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      else if (r < pop_cut)    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
      else if (r < search_cut) op = OP_SEARCH;
      else if (r < dump_cut)   op = OP_DUMP;
      else                     op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
      key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 7)] : rand64();
      year = ($urandom_range(0, 9) == 0) ? YEAR_W'($urandom_range(0, 16383))
                                         : YEAR_W'($urandom_range(0, 9999));
      return make_req(op, key, year, rand64(), rand64(), $urandom_range(0, 99) < 2);
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at response beat %0d: %s", rsp_beats, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_results(offered_req);
            req_beats <= req_beats + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < 12) begin
               req_gap = $urandom_range(0, 8);
               req_bus.valid <= 1'b0;
            end else if (req_items.size() != 0) begin
               offered_req = req_items.pop_front();
               req_bus.opcode <= offered_req.opcode;
               req_bus.model_key <= offered_req.key;
               req_bus.model_year <= offered_req.year;
               req_bus.brand_text <= offered_req.brand;
               req_bus.fuel_text <= offered_req.fuel;
               req_bus.clear_all <= offered_req.clear;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         quiet_tail <= (req_items.size() < QUIET_TAIL_ITEMS);
      end
   end

   // long response hold-off, once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (!hold_taken && req_beats >= HOLD_AFTER_BEATS) begin
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_beats.size() == 0) begin
               flag_mismatch("beat with nothing expected");
            end else begin
               exp_beat = expected_beats.pop_front();
               check_field("status", rsp_bus.status, exp_beat.status);
               check_field("out_key", rsp_bus.out_key, exp_beat.rec.key);
               check_field("out_year", rsp_bus.out_year, exp_beat.rec.year);
               check_field("out_brand", rsp_bus.out_brand, exp_beat.rec.brand);
               check_field("out_fuel", rsp_bus.out_fuel, exp_beat.rec.fuel);
               check_field("last_of_run", rsp_bus.last_of_run, exp_beat.last);
               check_field("fill_level", rsp_bus.fill_level, exp_beat.fill);
            end
            rsp_beats++;
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < 12) begin
            rsp_stall = $urandom_range(0, 8);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("** double_ended_queue_with_search_top: FAILED **");
      $finish;
   end

   initial begin
      int      made;
      int      run_len;
      int      j;
      mix_type mix;
      logic [KEY_W-1:0] ones;
      logic [KEY_W-1:0] sedan;

      req_bus.valid = 1'b0;
      req_bus.opcode = OP_PUSH_REAR;
      req_bus.model_key = '0;
      req_bus.model_year = '0;
      req_bus.brand_text = '0;
      req_bus.fuel_text = '0;
      req_bus.clear_all = 1'b0;
      rsp_bus.ready = 1'b0;
      shelf_head = 0;
      shelf_count = 0;
      req_beats = 0;
      rsp_beats = 0;
      mismatch_count = 0;
      quiet_tail = 1'b0;

      ones = '1;
      sedan = 64'h0000_0053_4544_414E;
      key_pool[0] = ones;
      key_pool[1] = '0;
      key_pool[2] = sedan;
      for (j = 3; j < 8; j++) key_pool[j] = rand64();

      // directed: empty errors, spare opcodes, field extremes, search, dump, clear
      req_items.push_back(make_req(OP_POP_FRONT, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_POP_REAR, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_SEARCH, ones, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_DUMP, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_SPARE_6, ones, '1, ones, ones, 1'b0));
      req_items.push_back(make_req(OP_PUSH_REAR, ones, '1, ones, ones, 1'b0));
      req_items.push_back(make_req(OP_PUSH_FRONT, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_PUSH_REAR, sedan, 14'd9999, rand64(), rand64(), 1'b0));
      req_items.push_back(make_req(OP_PUSH_FRONT, ones, 14'd2001, rand64(), rand64(), 1'b0));
      req_items.push_back(make_req(OP_SEARCH, ones, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_SEARCH, sedan, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_SEARCH, 64'h1234_5678_9ABC_DEF0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_DUMP, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_SPARE_7, rand64(), '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_POP_FRONT, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_POP_REAR, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_PUSH_REAR, rand64(), 14'd1999, rand64(), rand64(), 1'b1));
      req_items.push_back(make_req(OP_DUMP, '0, '0, '0, '0, 1'b0));
      req_items.push_back(make_req(OP_PUSH_REAR, sedan, 14'd1, rand64(), rand64(), 1'b0));
      req_items.push_back(make_req(OP_PUSH_FRONT, rand64(), 14'd8192, rand64(), rand64(), 1'b0));
      req_items.push_back(make_req(OP_SPARE_6, '0, '0, '0, '0, 1'b1));
      req_items.push_back(make_req(OP_PUSH_FRONT, rand64(), 14'd42, rand64(), rand64(), 1'b0));
      req_items.push_back(make_req(OP_POP_FRONT, '0, '0, '0, '0, 1'b0));

      // random runs; the first one fills the deque past full
      made = 0;
      mix = MIX_FILL;
      run_len = 42;
      while (made < RANDOM_ITEMS) begin
         for (j = 0; j < run_len && made < RANDOM_ITEMS; j++) begin
            req_items.push_back(random_req(mix));
            made++;
         end
         mix = mix_type'($urandom_range(0, 3));
         run_len = $urandom_range(10, 45);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (req_items.size() != 0 || req_bus.valid || expected_beats.size() != 0);
      repeat (2 * DEPTH + 10) @(posedge clock);

      if (mismatch_count == 0)
         $display("** double_ended_queue_with_search_top: PASSED **");
      else
         $display("** double_ended_queue_with_search_top: FAILED **");
      $finish;
   end

endmodule
